// ===== hw/rtl/bdlp_pkg.sv =====
// Shared types, codes and reset values for the button debounce and long-press block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package bdlp_pkg;

    localparam int TIME_WIDTH_DEFAULT  = 32;
    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int CFG_INDEX_W         = 3;
    localparam int CFG_DATA_W          = 16;

    localparam logic [15:0] DEBOUNCE_RESET   = 16'd20;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd500;
    localparam logic [15:0] KEY_CODE_RESET   = 16'd0;
    localparam logic [7:0]  SOURCE_RESET     = 8'd0;

    localparam logic CMD_SCAN  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef enum logic [1:0] {
        KIND_WHEEL = 2'd0,
        KIND_DOWN  = 2'd1,
        KIND_UP    = 2'd2,
        KIND_LONG  = 2'd3
    } t_kind;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEBOUNCE   = 3'd0,
        REG_LONG_PRESS = 3'd1,
        REG_KEY_CODE   = 3'd2,
        REG_SOURCE     = 3'd3,
        REG_WHEEL_EN   = 3'd4,
        REG_BUTTON_EN  = 3'd5
    } t_reg_index;

    typedef struct packed {
        logic               command;
        logic [31:0]        now_time;
        logic signed [15:0] wheel_delta;
        logic               switch_level;
    } t_in_word;

    typedef struct packed {
        t_kind              event_kind;
        logic signed [15:0] event_delta;
        logic [15:0]        event_code;
        logic [7:0]         event_source;
        logic [31:0]        event_time;
        logic               last_event;
    } t_out_word;

    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } t_cfg_write;

    // The events caused by one scan, waiting to be sent in order.
    typedef struct packed {
        logic               wheel_v;
        logic               button_v;
        logic               button_up;
        logic               long_v;
        logic signed [15:0] delta;
        logic [15:0]        code;
        logic [7:0]         source;
        logic [31:0]        stamp;
    } t_bundle;

endpackage

`default_nettype wire

// ===== hw/rtl/bdlp_front.sv =====
// Front end: configuration registers, debounce and long-press state, event classification.
// Depends on bdlp_pkg; pushes one bundle per eventful scan into the queue.
`default_nettype none

module bdlp_front #(
    parameter int TIME_WIDTH = bdlp_pkg::TIME_WIDTH_DEFAULT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire bdlp_pkg::t_cfg_write i_cfg,
    input  wire logic                 i_in_valid,
    input  wire bdlp_pkg::t_in_word   i_in_word,
    input  wire logic                 i_full,
    output logic                      o_push,
    output bdlp_pkg::t_bundle         o_bundle
);
    import bdlp_pkg::*;

    logic [15:0] r_debounce;
    logic [15:0] r_long_press;
    logic [15:0] r_key_code;
    logic [7:0]  r_source;
    logic        r_wheel_en;
    logic        r_button_en;

    logic                  r_raw, n_raw;
    logic                  r_stable, n_stable;
    logic                  r_press, n_press;
    logic                  r_long_sent, n_long_sent;
    logic [TIME_WIDTH-1:0] r_change_time, n_change_time;
    logic [TIME_WIDTH-1:0] r_press_time, n_press_time;

    logic                  w_accept;
    logic                  w_level;
    logic [TIME_WIDTH-1:0] w_now;
    logic [TIME_WIDTH-1:0] w_chg;
    logic [TIME_WIDTH-1:0] w_deb_diff;
    logic [TIME_WIDTH-1:0] w_press_diff;
    logic                  w_settle;
    logic                  w_wheel_v;
    logic                  w_button_v;
    logic                  w_long_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= DEBOUNCE_RESET;
            r_long_press <= LONG_PRESS_RESET;
            r_key_code   <= KEY_CODE_RESET;
            r_source     <= SOURCE_RESET;
            r_wheel_en   <= 1'b1;
            r_button_en  <= 1'b1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_DEBOUNCE:   r_debounce   <= i_cfg.data;
                REG_LONG_PRESS: r_long_press <= i_cfg.data;
                REG_KEY_CODE:   r_key_code   <= i_cfg.data;
                REG_SOURCE:     r_source     <= i_cfg.data[7:0];
                REG_WHEEL_EN:   r_wheel_en   <= i_cfg.data[0];
                REG_BUTTON_EN:  r_button_en  <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    assign w_accept     = i_in_valid && !i_full;
    assign w_level      = i_in_word.switch_level;
    assign w_now        = TIME_WIDTH'(i_in_word.now_time);
    assign w_chg        = (w_level != r_raw) ? w_now : r_change_time;
    assign w_deb_diff   = w_now - w_chg;
    assign w_press_diff = w_now - r_press_time;
    assign w_settle     = (w_level != r_stable) &&
                          (w_deb_diff >= TIME_WIDTH'(r_debounce));

    always_comb begin
        n_raw         = r_raw;
        n_stable      = r_stable;
        n_press       = r_press;
        n_long_sent   = r_long_sent;
        n_change_time = r_change_time;
        n_press_time  = r_press_time;
        w_wheel_v     = r_wheel_en && (i_in_word.wheel_delta != 16'sd0);
        w_button_v    = 1'b0;
        w_long_v      = 1'b0;

        if (r_button_en) begin
            n_raw         = w_level;
            n_change_time = w_chg;
            if (w_settle) begin
                n_stable    = w_level;
                n_press     = w_level;
                n_long_sent = 1'b0;
                w_button_v  = w_level || r_press;
                if (w_level) begin
                    n_press_time = w_now;
                end
            end
            w_long_v = n_press && !n_long_sent && (r_long_press != 16'd0) &&
                       !(w_settle && w_level) &&
                       (w_press_diff >= TIME_WIDTH'(r_long_press));
            if (w_long_v) begin
                n_long_sent = 1'b1;
            end
        end

        if (i_in_word.command == CMD_START) begin
            n_raw         = r_button_en && w_level;
            n_stable      = r_button_en && w_level;
            n_press       = 1'b0;
            n_long_sent   = 1'b0;
            n_change_time = '0;
            n_press_time  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw         <= 1'b0;
            r_stable      <= 1'b0;
            r_press       <= 1'b0;
            r_long_sent   <= 1'b0;
            r_change_time <= '0;
            r_press_time  <= '0;
        end else if (w_accept) begin
            r_raw         <= n_raw;
            r_stable      <= n_stable;
            r_press       <= n_press;
            r_long_sent   <= n_long_sent;
            r_change_time <= n_change_time;
            r_press_time  <= n_press_time;
        end
    end

    assign o_push = w_accept && (i_in_word.command == CMD_SCAN) &&
                    (w_wheel_v || w_button_v || w_long_v);

    always_comb begin
        o_bundle.wheel_v   = w_wheel_v;
        o_bundle.button_v  = w_button_v;
        o_bundle.button_up = !w_level;
        o_bundle.long_v    = w_long_v;
        o_bundle.delta     = i_in_word.wheel_delta;
        o_bundle.code      = r_key_code;
        o_bundle.source    = r_source;
        o_bundle.stamp     = 32'(w_now);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bdlp_queue.sv =====
// Short register queue of event bundles between the front end and the emitter.
// Depends on bdlp_pkg for the bundle type.
`default_nettype none

module bdlp_queue #(
    parameter int DEPTH = bdlp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire bdlp_pkg::t_bundle i_bundle,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_head_valid,
    output bdlp_pkg::t_bundle      o_head
);
    import bdlp_pkg::*;

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    t_bundle            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [COUNT_W-1:0] r_count, n_count;

    assign o_full       = (r_count == COUNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bdlp_back.sv =====
// Back end: splits the head bundle into registered event words, one a cycle unless stalled.
// Depends on bdlp_pkg for the bundle and output word types.
`default_nettype none

module bdlp_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_head_valid,
    input  wire bdlp_pkg::t_bundle i_head,
    output logic                   o_pop,
    output logic                   o_out_valid,
    output bdlp_pkg::t_out_word    o_out_word,
    input  wire logic              i_out_stall
);
    import bdlp_pkg::*;

    logic      r_valid, n_valid;
    logic [2:0] r_done, n_done;
    t_out_word r_word, n_word;

    logic       w_load;
    logic [2:0] w_pend;
    logic [2:0] w_sel;
    logic       w_last;

    assign w_load = !r_valid || !i_out_stall;
    assign w_pend = {i_head.long_v, i_head.button_v, i_head.wheel_v} & ~r_done &
                    {3{i_head_valid}};

    always_comb begin
        if (w_pend[0]) begin
            w_sel = 3'b001;
        end else if (w_pend[1]) begin
            w_sel = 3'b010;
        end else begin
            w_sel = {w_pend[2], 2'b00};
        end
        w_last = (w_pend & ~w_sel) == 3'b000;

        n_valid = r_valid;
        n_done  = r_done;
        n_word  = r_word;
        o_pop   = 1'b0;
        if (w_load) begin
            n_valid = (w_pend != 3'b000);
            n_word.event_source = i_head.source;
            n_word.event_time   = i_head.stamp;
            n_word.last_event   = w_last;
            if (w_sel[0]) begin
                n_word.event_kind  = KIND_WHEEL;
                n_word.event_delta = i_head.delta;
                n_word.event_code  = 16'd0;
            end else begin
                n_word.event_kind  = w_sel[1] ? (i_head.button_up ? KIND_UP : KIND_DOWN)
                                              : KIND_LONG;
                n_word.event_delta = 16'sd0;
                n_word.event_code  = i_head.code;
            end
            if (w_pend != 3'b000) begin
                o_pop  = w_last;
                n_done = w_last ? 3'b000 : (r_done | w_sel);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= 3'b000;
        end else begin
            r_valid <= n_valid;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

endmodule

`default_nettype wire

// ===== hw/rtl/button_debounce_long_press.sv =====
// Top level of the debounced button with long-press detection and wheel events.
// Depends on bdlp_pkg, bdlp_front, bdlp_queue and bdlp_back.
//
//   Channel   Signals                                   Moves
//   input     i_in_valid / o_in_stall / i_in_word       one scan or start word
//   output    o_out_valid / i_out_stall / o_out_word    one event word
//   config    i_cfg_valid / o_cfg_ready / index, data   one register write
//
// A scan word is classified in the cycle it is accepted; a new one may follow every cycle
// while the bundle queue has room. The emitter sends one event word a cycle unless the output
// stalls; a scan causes up to two events, each sent as its own word from the output register.
// Reset is synchronous and clears all control state; configuration returns to its defaults.
// Input stall rises only when the queue is full; a stalled output word holds its value.
`default_nettype none

module button_debounce_long_press #(
    parameter int TIME_WIDTH  = bdlp_pkg::TIME_WIDTH_DEFAULT,
    parameter int QUEUE_DEPTH = bdlp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire bdlp_pkg::t_in_word                 i_in_word,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output bdlp_pkg::t_out_word                     o_out_word,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [bdlp_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [bdlp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bdlp_pkg::*;

    t_cfg_write w_cfg;
    logic       w_push;
    t_bundle    w_bundle;
    logic       w_full;
    logic       w_pop;
    logic       w_head_valid;
    t_bundle    w_head;

    assign o_cfg_ready = 1'b1;
    assign w_cfg.valid = i_cfg_valid;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;
    assign o_in_stall  = w_full;

    bdlp_front #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_bundle   (w_bundle)
    );

    bdlp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_bundle     (w_bundle),
        .i_pop        (w_pop),
        .o_full       (w_full),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    bdlp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .o_out_word   (o_out_word),
        .i_out_stall  (i_out_stall)
    );

    a_pop_gives_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (o_out_valid && o_out_word.last_event))
        else $error("queue head retired without a final event word");

    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head_valid)
        else $error("queue popped while empty");

    a_wheel_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.event_kind == KIND_WHEEL) |->
            (o_out_word.event_code == 16'd0))
        else $error("wheel event carries a key code");

    a_button_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.event_kind != KIND_WHEEL) |->
            (o_out_word.event_delta == 16'sd0))
        else $error("button event carries a wheel delta");

endmodule

`default_nettype wire
